[rtl/ltp_pkg.sv]
// Shared types and constants for the loopback pattern tester.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none
package ltp_pkg;

    // Mode codes of an input word
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_STOP  = 2'd1;
    localparam logic [1:0] MODE_RX    = 2'd2;
    localparam logic [1:0] MODE_PULL  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_SIZE_SELECT    = 2'd0;
    localparam logic [1:0] CFG_PATTERN_SELECT = 2'd1;
    localparam logic [1:0] CFG_LOOP_DEPTH     = 2'd2;
    localparam logic [1:0] CFG_ON_ERROR_MODE  = 2'd3;
    localparam int unsigned CFG_DATA_W = 2;

    // Packet size codes and lengths
    localparam logic [1:0] SIZE_128 = 2'd1;
    localparam logic [1:0] SIZE_250 = 2'd2;
    localparam logic [7:0] LEN_32   = 8'd32;
    localparam logic [7:0] LEN_128  = 8'd128;
    localparam logic [7:0] LEN_250  = 8'd250;

    // Echo index limit and transmit queue ceiling
    localparam int unsigned RX_IDX_W   = 11;
    localparam logic [RX_IDX_W-1:0] RX_LEN_MAX = 11'd1024;
    localparam logic [2:0] PENDING_MAX = 3'd7;

    // One input word
    typedef struct packed {
        logic [1:0]          mode;
        logic [7:0]          rx_byte;
        logic                rx_last;
        logic [RX_IDX_W-1:0] rx_length;
    } in_word_t;

    // One result word
    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic        byte_error;
        logic        running;
        logic [31:0] tx_packets;
        logic [31:0] rx_packets;
        logic [31:0] error_total;
    } result_t;

    // Configuration write bundle
    typedef struct packed {
        logic                  write;
        logic [1:0]            index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_write_t;

endpackage
`default_nettype wire

[rtl/loopback_pattern_tester_core.sv]
// Top level of the loopback pattern tester: input register, engine, result register.
// Depends on ltp_pkg, ltp_in_reg, ltp_engine and ltp_out_reg.
//
// Usage:
// - Input channel (in_valid / in_stall) carries one word per command: start, stop,
//   echoed byte (rx_byte, rx_last, rx_length) or pull of the next transmit byte.
// - Output channel (out_valid / out_stall) returns exactly one result word per
//   input word, in order: the generated byte, the mismatch flag, the running
//   flag and the three 32-bit counters after that word.
// - A word passes through the input register and then the result register on its way to
//   out_valid; throughput is one word per cycle while the receiver does not stall. The
//   engine updates its state in the cycle a word moves from the input register into the result register.
// - When the receiver stalls, the result register holds its word and the input
//   register still takes one more word; in_stall rises only when both are full.
// - Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once and
//   are ignored while a test is running.
// - Reset clears configuration, counters and the valid flags of both register stages.
`default_nettype none
module loopback_pattern_tester_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [ltp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  mode,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        rx_last,
    input  wire logic [ltp_pkg::RX_IDX_W-1:0] rx_length,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             tx_valid,
    output logic [7:0]       tx_byte,
    output logic             tx_last,
    output logic             byte_error,
    output logic             running,
    output logic [31:0]      tx_packets,
    output logic [31:0]      rx_packets,
    output logic [31:0]      error_total
);
    import ltp_pkg::*;

    in_word_t   in_word;
    in_word_t   word;
    logic       word_valid;
    logic       advance;
    cfg_write_t cfg;
    result_t    result;
    result_t    out_word;

    assign in_word.mode      = mode;
    assign in_word.rx_byte   = rx_byte;
    assign in_word.rx_last   = rx_last;
    assign in_word.rx_length = rx_length;

    assign cfg.write = cfg_write;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    ltp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_word    (in_word),
        .in_stall   (in_stall),
        .advance    (advance),
        .word_valid (word_valid),
        .word       (word)
    );

    ltp_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .fire   (word_valid && advance),
        .word   (word),
        .result (result)
    );

    ltp_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .result     (result),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word)
    );

    assign tx_valid    = out_word.tx_valid;
    assign tx_byte     = out_word.tx_byte;
    assign tx_last     = out_word.tx_last;
    assign byte_error  = out_word.byte_error;
    assign running     = out_word.running;
    assign tx_packets  = out_word.tx_packets;
    assign rx_packets  = out_word.rx_packets;
    assign error_total = out_word.error_total;

endmodule
`default_nettype wire

[rtl/ltp_in_reg.sv]
// Input register stage of the loopback pattern tester.
// Depends on ltp_pkg for the input word type.
`default_nettype none
module ltp_in_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire ltp_pkg::in_word_t in_word,
    output logic                  in_stall,
    input  wire logic             advance,
    output logic                  word_valid,
    output ltp_pkg::in_word_t     word
);
    import ltp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;

    // Hold the word while the engine cannot move it on
    assign in_stall   = valid_reg && !advance;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            word_reg <= in_word;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule
`default_nettype wire

[rtl/ltp_engine.sv]
// Test state, configuration registers and per-word next-state logic.
// Depends on ltp_pkg for word types, mode codes and constants.
`default_nettype none
module ltp_engine (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ltp_pkg::cfg_write_t cfg,
    input  wire logic              fire,
    input  wire ltp_pkg::in_word_t word,
    output ltp_pkg::result_t       result
);
    import ltp_pkg::*;

    // Configuration
    logic [1:0] size_select_reg;
    logic       pattern_select_reg;
    logic       loop_depth_reg;
    logic       on_error_mode_reg;

    // Test state
    logic                running_reg,     running_next;
    logic [RX_IDX_W-1:0] rx_index_reg,    rx_index_next;
    logic                rx_in_packet_reg, rx_in_packet_next;
    logic                rx_checking_reg, rx_checking_next;
    logic [2:0]          tx_pending_reg,  tx_pending_next;
    logic [7:0]          tx_index_reg,    tx_index_next;
    logic [31:0]         tx_total_reg,    tx_total_next;
    logic [31:0]         rx_total_reg,    rx_total_next;
    logic [31:0]         err_total_reg,   err_total_next;

    logic                tx_valid;
    logic [7:0]          tx_byte;
    logic                tx_last;
    logic                byte_error;
    logic [7:0]          pkt_len;
    logic [7:0]          pkt_last_idx;
    logic [RX_IDX_W-1:0] rx_limit;
    logic [7:0]          rx_expect;
    logic                rx_open;

    // Register writes are dropped while a test runs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_select_reg    <= 2'd0;
            pattern_select_reg <= 1'b0;
            loop_depth_reg     <= 1'b0;
            on_error_mode_reg  <= 1'b0;
        end
        else if (cfg.write && !running_reg)
        begin
            case (cfg.index)
                CFG_SIZE_SELECT:    size_select_reg    <= cfg.data[1:0];
                CFG_PATTERN_SELECT: pattern_select_reg <= cfg.data[0];
                CFG_LOOP_DEPTH:     loop_depth_reg     <= cfg.data[0];
                CFG_ON_ERROR_MODE:  on_error_mode_reg  <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // Packet length from the size code
    always_comb
    begin
        case (size_select_reg)
            SIZE_128: pkt_len = LEN_128;
            SIZE_250: pkt_len = LEN_250;
            default:  pkt_len = LEN_32;
        endcase
    end
    assign pkt_last_idx = pkt_len - 8'd1;

    // Echo checking limit and expected byte
    assign rx_limit  = (word.rx_length < RX_LEN_MAX) ? word.rx_length : RX_LEN_MAX;
    assign rx_expect = pattern_select_reg
                     ? (word.rx_length[7:0] - 8'd1 - rx_index_reg[7:0])
                     : rx_index_reg[7:0];

    // Next state for one word
    always_comb
    begin
        running_next      = running_reg;
        rx_index_next     = rx_index_reg;
        rx_in_packet_next = rx_in_packet_reg;
        rx_checking_next  = rx_checking_reg;
        tx_pending_next   = tx_pending_reg;
        tx_index_next     = tx_index_reg;
        tx_total_next     = tx_total_reg;
        rx_total_next     = rx_total_reg;
        err_total_next    = err_total_reg;
        tx_valid          = 1'b0;
        tx_byte           = 8'd0;
        tx_last           = 1'b0;
        byte_error        = 1'b0;
        rx_open           = rx_in_packet_reg;

        case (word.mode)
            MODE_START:
            begin
                running_next      = 1'b1;
                rx_total_next     = 32'd0;
                err_total_next    = 32'd0;
                tx_index_next     = 8'd0;
                rx_index_next     = '0;
                rx_in_packet_next = 1'b0;
                rx_checking_next  = 1'b0;
                tx_pending_next   = loop_depth_reg ? 3'd2 : 3'd1;
                tx_total_next     = loop_depth_reg ? 32'd2 : 32'd1;
            end
            MODE_STOP:
            begin
                running_next = 1'b0;
            end
            MODE_RX:
            begin
                // A new echo opens only while running
                if (!rx_in_packet_reg && running_reg)
                begin
                    rx_open          = 1'b1;
                    rx_checking_next = 1'b1;
                    rx_index_next    = '0;
                end
                if (rx_open)
                begin
                    rx_in_packet_next = 1'b1;
                    // Fresh packets start at index zero with checking on
                    if (((!rx_in_packet_reg) || rx_checking_reg)
                        && ((rx_in_packet_reg ? rx_index_reg : '0) < rx_limit)
                        && (word.rx_byte != (rx_in_packet_reg ? rx_expect
                            : (pattern_select_reg ? (word.rx_length[7:0] - 8'd1)
                                                  : 8'd0))))
                    begin
                        byte_error     = 1'b1;
                        err_total_next = err_total_reg + 32'd1;
                        if (!on_error_mode_reg)
                        begin
                            running_next     = 1'b0;
                            rx_checking_next = 1'b0;
                        end
                    end
                    if (!rx_in_packet_reg)
                    begin
                        rx_index_next = {{(RX_IDX_W-1){1'b0}}, 1'b1};
                    end
                    else if (rx_index_reg < RX_LEN_MAX)
                    begin
                        rx_index_next = rx_index_reg + 1'b1;
                    end
                    if (word.rx_last)
                    begin
                        rx_total_next = rx_total_reg + 32'd1;
                        if (running_next)
                        begin
                            if (tx_pending_reg < PENDING_MAX)
                            begin
                                tx_pending_next = tx_pending_reg + 3'd1;
                            end
                            tx_total_next = tx_total_reg + 32'd1;
                        end
                        rx_in_packet_next = 1'b0;
                        rx_checking_next  = 1'b0;
                        rx_index_next     = '0;
                    end
                end
            end
            MODE_PULL:
            begin
                if (tx_pending_reg != 3'd0)
                begin
                    tx_valid = 1'b1;
                    tx_byte  = pattern_select_reg ? (pkt_last_idx - tx_index_reg)
                                                  : tx_index_reg;
                    if (tx_index_reg >= pkt_last_idx)
                    begin
                        tx_last         = 1'b1;
                        tx_index_next   = 8'd0;
                        tx_pending_next = tx_pending_reg - 3'd1;
                    end
                    else
                    begin
                        tx_index_next = tx_index_reg + 8'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg      <= 1'b0;
            rx_index_reg     <= '0;
            rx_in_packet_reg <= 1'b0;
            rx_checking_reg  <= 1'b0;
            tx_pending_reg   <= 3'd0;
            tx_index_reg     <= 8'd0;
            tx_total_reg     <= 32'd0;
            rx_total_reg     <= 32'd0;
            err_total_reg    <= 32'd0;
        end
        else if (fire)
        begin
            running_reg      <= running_next;
            rx_index_reg     <= rx_index_next;
            rx_in_packet_reg <= rx_in_packet_next;
            rx_checking_reg  <= rx_checking_next;
            tx_pending_reg   <= tx_pending_next;
            tx_index_reg     <= tx_index_next;
            tx_total_reg     <= tx_total_next;
            rx_total_reg     <= rx_total_next;
            err_total_reg    <= err_total_next;
        end
    end

    // Result word reflects state after this word
    always_comb
    begin
        result.tx_valid    = tx_valid;
        result.tx_byte     = tx_byte;
        result.tx_last     = tx_last;
        result.byte_error  = byte_error;
        result.running     = running_next;
        result.tx_packets  = tx_total_next;
        result.rx_packets  = rx_total_next;
        result.error_total = err_total_next;
    end

endmodule
`default_nettype wire

[rtl/ltp_out_reg.sv]
// Result register stage of the loopback pattern tester.
// Depends on ltp_pkg for the result word type.
`default_nettype none
module ltp_out_reg (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            word_valid,
    input  wire ltp_pkg::result_t result,
    output logic                 advance,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output ltp_pkg::result_t     out_word
);
    import ltp_pkg::*;

    logic    valid_reg;
    result_t word_reg;

    // Load when empty or when the held word is taken
    assign advance = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= word_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && word_valid)
        begin
            word_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule
`default_nettype wire

[tb/sv/ltp_result_checker.sv]
`timescale 1ns / 1ps
// Result checker for the loopback pattern tester: predicts each result word and compares.
// Depends on ltp_pkg; watches the config port and both channels of the core.
module ltp_result_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [ltp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [1:0]  mode,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        rx_last,
    input  wire logic [ltp_pkg::RX_IDX_W-1:0] rx_length,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic        tx_valid,
    input  wire logic [7:0]  tx_byte,
    input  wire logic        tx_last,
    input  wire logic        byte_error,
    input  wire logic        running,
    input  wire logic [31:0] tx_packets,
    input  wire logic [31:0] rx_packets,
    input  wire logic [31:0] error_total,
    output int               fail_count,
    output int               results_waiting,
    output int               results_checked,
    output int               flagged_bytes,
    output int               packets_closed
);
    import ltp_pkg::*;

    localparam int MAX_REPORTS = 10;

    // Shadow configuration
    logic [1:0] cfg_size = '0;
    logic       cfg_down = 1'b0;
    logic       cfg_two  = 1'b0;
    logic       cfg_cont = 1'b0;

    // Shadow tester state
    logic                run_flag   = 1'b0;
    logic [RX_IDX_W-1:0] echo_idx   = '0;
    logic                echo_open  = 1'b0;
    logic                echo_check = 1'b0;
    logic [2:0]          tx_queued  = '0;
    logic [7:0]          tx_idx     = '0;
    logic [31:0]         tx_count   = '0;
    logic [31:0]         rx_count   = '0;
    logic [31:0]         err_count  = '0;

    result_t expected_results[$];
    int      fails;
    int      checked;
    int      flagged;
    int      closed;

    // Queue one test packet; the queue saturates but the count still moves
    function automatic void queue_packet();
        if (tx_queued < PENDING_MAX)
            tx_queued = tx_queued + 3'd1;
        tx_count = tx_count + 32'd1;
    endfunction

    // Advance the shadow state by one input word and return the result it causes
    function automatic result_t next_result(input in_word_t w);
        result_t             r;
        logic [RX_IDX_W-1:0] limit;
        logic [RX_IDX_W-1:0] down;
        logic [7:0]          pat_byte;
        logic [7:0]          plen;
        r = '0;
        case (w.mode)
            MODE_START:
            begin
                run_flag   = 1'b1;
                tx_count   = '0;
                rx_count   = '0;
                err_count  = '0;
                tx_idx     = '0;
                tx_queued  = '0;
                echo_idx   = '0;
                echo_open  = 1'b0;
                echo_check = 1'b0;
                queue_packet();
                if (cfg_two)
                    queue_packet();
            end
            MODE_STOP:
            begin
                run_flag = 1'b0;
            end
            MODE_RX:
            begin
                // a new echo only opens while running
                if (!echo_open && run_flag)
                begin
                    echo_open  = 1'b1;
                    echo_check = 1'b1;
                    echo_idx   = '0;
                end
                if (echo_open)
                begin
                    limit = (w.rx_length < RX_LEN_MAX) ? w.rx_length : RX_LEN_MAX;
                    if (echo_check && echo_idx < limit)
                    begin
                        down     = w.rx_length - 11'd1 - echo_idx;
                        pat_byte = cfg_down ? down[7:0] : echo_idx[7:0];
                        if (w.rx_byte != pat_byte)
                        begin
                            r.byte_error = 1'b1;
                            err_count    = err_count + 32'd1;
                            if (!cfg_cont)
                            begin
                                run_flag   = 1'b0;
                                echo_check = 1'b0;
                            end
                        end
                    end
                    if (echo_idx < RX_LEN_MAX)
                        echo_idx = echo_idx + 11'd1;
                    if (w.rx_last)
                    begin
                        rx_count = rx_count + 32'd1;
                        if (run_flag)
                            queue_packet();
                        echo_open  = 1'b0;
                        echo_check = 1'b0;
                        echo_idx   = '0;
                    end
                end
            end
            default:
            begin
                // pull: one byte of the head packet, length read live
                if (tx_queued != 3'd0)
                begin
                    case (cfg_size)
                        SIZE_128: plen = LEN_128;
                        SIZE_250: plen = LEN_250;
                        default:  plen = LEN_32;
                    endcase
                    r.tx_valid = 1'b1;
                    r.tx_byte  = cfg_down ? plen - 8'd1 - tx_idx : tx_idx;
                    if (tx_idx >= plen - 8'd1)
                    begin
                        r.tx_last = 1'b1;
                        tx_idx    = '0;
                        tx_queued = tx_queued - 3'd1;
                    end
                    else
                    begin
                        tx_idx = tx_idx + 8'd1;
                    end
                end
            end
        endcase
        r.running     = run_flag;
        r.tx_packets  = tx_count;
        r.rx_packets  = rx_count;
        r.error_total = err_count;
        return r;
    endfunction

    // Watch config writes and both channels
    always @(posedge clk or negedge rst_n)
    begin : watch
        in_word_t w;
        result_t  got;
        result_t  want;
        if (!rst_n)
        begin
            cfg_size   = '0;
            cfg_down   = 1'b0;
            cfg_two    = 1'b0;
            cfg_cont   = 1'b0;
            run_flag   = 1'b0;
            echo_idx   = '0;
            echo_open  = 1'b0;
            echo_check = 1'b0;
            tx_queued  = '0;
            tx_idx     = '0;
            tx_count   = '0;
            rx_count   = '0;
            err_count  = '0;
            expected_results.delete();
            fails   = 0;
            checked = 0;
            flagged = 0;
            closed  = 0;
        end
        else
        begin
            // register writes are dropped while a test runs
            if (cfg_write && !run_flag)
            begin
                case (cfg_index)
                    CFG_SIZE_SELECT:    cfg_size = cfg_data[1:0];
                    CFG_PATTERN_SELECT: cfg_down = cfg_data[0];
                    CFG_LOOP_DEPTH:     cfg_two  = cfg_data[0];
                    CFG_ON_ERROR_MODE:  cfg_cont = cfg_data[0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                w = {mode, rx_byte, rx_last, rx_length};
                expected_results.push_back(next_result(w));
            end

            if (out_valid && !out_stall)
            begin
                got = {tx_valid, tx_byte, tx_last, byte_error, running,
                       tx_packets, rx_packets, error_total};
                if (expected_results.size() == 0)
                begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("checker: result word with nothing expected at %0t", $realtime);
                end
                else
                begin
                    want = expected_results.pop_front();
                    checked++;
                    if (want.byte_error)
                        flagged++;
                    if (want.tx_last)
                        closed++;
                    if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
                        got.tx_last !== want.tx_last || got.byte_error !== want.byte_error ||
                        got.running !== want.running || got.tx_packets !== want.tx_packets ||
                        got.rx_packets !== want.rx_packets ||
                        got.error_total !== want.error_total)
                    begin
                        fails++;
                        if (fails <= MAX_REPORTS)
                        begin
                            $display("checker: word %0d expected tx %b %h %b err %b run %b %0d %0d %0d",
                                     checked, want.tx_valid, want.tx_byte, want.tx_last,
                                     want.byte_error, want.running, want.tx_packets,
                                     want.rx_packets, want.error_total);
                            $display("checker: word %0d actual   tx %b %h %b err %b run %b %0d %0d %0d",
                                     checked, got.tx_valid, got.tx_byte, got.tx_last,
                                     got.byte_error, got.running, got.tx_packets,
                                     got.rx_packets, got.error_total);
                        end
                    end
                end
            end
        end
        fail_count      <= fails;
        results_waiting <= expected_results.size();
        results_checked <= checked;
        flagged_bytes   <= flagged;
        packets_closed  <= closed;
    end

endmodule

[tb/sv/loopback_pattern_tester_core_tb.sv]
`timescale 1ns / 1ps
// Testbench top for loopback_pattern_tester_core: clock, reset, stimulus, verdict.
// Depends on ltp_pkg, the core and ltp_result_checker.
module loopback_pattern_tester_core_tb;
    import ltp_pkg::*;

    localparam logic [1:0] SIZE_32     = 2'd0;
    localparam logic [1:0] SIZE_32_ALT = 2'd3;
    localparam logic       PAT_UP      = 1'b0;
    localparam logic       PAT_DOWN    = 1'b1;
    localparam logic       ONE_PACKET  = 1'b0;
    localparam logic       TWO_PACKETS = 1'b1;
    localparam logic       STOP_ON_ERR = 1'b0;
    localparam logic       KEEP_GOING  = 1'b1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_WORDS = 70;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [1:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic [1:0]            mode      = '0;
    logic [7:0]            rx_byte   = '0;
    logic                  rx_last   = 1'b0;
    logic [RX_IDX_W-1:0]   rx_length = '0;
    logic                  out_stall = 1'b0;
    logic                  in_stall;
    logic                  out_valid;
    logic                  tx_valid;
    logic [7:0]            tx_byte;
    logic                  tx_last;
    logic                  byte_error;
    logic                  running;
    logic [31:0]           tx_packets;
    logic [31:0]           rx_packets;
    logic [31:0]           error_total;

    int fail_count;
    int results_waiting;
    int results_checked;
    int flagged_bytes;
    int packets_closed;

    int cycles        = 0;
    int words_applied = 0;
    int send_idle_pct = 0;
    int out_stall_pct = 0;

    // Shadow of the settings that took effect, used to build echoes
    int   sh_len  = 32;
    logic sh_down = PAT_UP;
    logic sh_cont = STOP_ON_ERR;
    logic need_start = 1'b1;

    loopback_pattern_tester_core DUT (.*);

    ltp_result_checker u_checker (.*);

    always #1 clk = ~clk;

    // Receiver stall
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < out_stall_pct);

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offer one word after a random idle gap and hold it until taken
    task automatic send_word(input logic [1:0] m, input logic [7:0] b, input logic l,
                             input logic [RX_IDX_W-1:0] n);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        rx_byte   <= b;
        rx_last   <= l;
        rx_length <= n;
        do
            @(posedge clk);
        while (in_stall);
        words_applied++;
    endtask

    // Start, stop or pull; the data fields are don't-care and random
    task automatic send_ctl(input logic [1:0] m);
        send_word(m, 8'($urandom), 1'($urandom), 11'($urandom_range(1024, 1)));
    endtask

    // Drop valid and wait until every expected word has come back
    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_waiting != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One register write; leaves cfg_write high for back-to-back writes
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
    endtask

    // Full setting; the test must be stopped so the writes land
    task automatic load_config(input logic [1:0] sz, input logic pat, input logic dep,
                               input logic cont);
        write_reg(CFG_SIZE_SELECT, sz);
        write_reg(CFG_PATTERN_SELECT, {1'b0, pat});
        write_reg(CFG_LOOP_DEPTH, {1'b0, dep});
        write_reg(CFG_ON_ERROR_MODE, {1'b0, cont});
        cfg_write <= 1'b0;
        case (sz)
            SIZE_128: sh_len = 128;
            SIZE_250: sh_len = 250;
            default:  sh_len = 32;
        endcase
        sh_down = pat;
        sh_cont = cont;
    endtask

    function automatic logic [7:0] echo_pattern(input int idx);
        int v;
        v = sh_down ? sh_len - 1 - idx : idx;
        return v[7:0];
    endfunction

    // One random scenario; mostly clean round trips
    task automatic play_round();
        int   pick;
        int   cut;
        int   k;
        logic [7:0] b;
        logic [RX_IDX_W-1:0] n;
        logic spoiled;
        pick    = $urandom_range(99);
        spoiled = 1'b0;
        if (pick < 70)
        begin
            // pull a packet and echo it back, sometimes with a bad byte or length
            if (need_start || $urandom_range(99) < 8)
                send_ctl(MODE_START);
            repeat (sh_len) send_ctl(MODE_PULL);
            n = 11'(sh_len);
            if ($urandom_range(99) < 10)
            begin
                n       = 11'($urandom_range(1024, 1));
                spoiled = 1'b1;
            end
            cut = ($urandom_range(99) < 25) ? $urandom_range(sh_len - 1) : -1;
            for (k = 0; k < sh_len; k++)
            begin
                b = echo_pattern(k);
                if (k == cut)
                begin
                    b       = b ^ (8'd1 << $urandom_range(7));
                    spoiled = 1'b1;
                end
                send_word(MODE_RX, b, k == sh_len - 1, n);
            end
            need_start = spoiled && !sh_cont;
        end
        else if (pick < 80)
        begin
            // one-byte echoes pile up the transmit queue
            repeat ($urandom_range(9, 2)) send_word(MODE_RX, 8'h00, 1'b1, 11'd1);
            if (sh_len == 32 && $urandom_range(99) < 30)
                repeat (8 * sh_len) send_ctl(MODE_PULL);
        end
        else if (pick < 88)
        begin
            // noise
            repeat ($urandom_range(6, 1))
                send_word(2'($urandom_range(3)), 8'($urandom), 1'($urandom),
                          11'($urandom_range(1024, 1)));
            need_start = 1'b1;
        end
        else if (pick < 94)
        begin
            // stop lands inside an echo
            send_ctl(MODE_START);
            cut = $urandom_range(sh_len - 2, 1);
            for (k = 0; k < sh_len; k++)
            begin
                if (k == cut)
                    send_ctl(MODE_STOP);
                send_word(MODE_RX, echo_pattern(k), k == sh_len - 1, 11'(sh_len));
            end
            need_start = 1'b1;
        end
        else
        begin
            // restart with a packet half sent and an echo half received
            repeat ($urandom_range(sh_len - 1, 1)) send_ctl(MODE_PULL);
            cut = $urandom_range(5, 1);
            for (k = 0; k < cut; k++)
                send_word(MODE_RX, echo_pattern(k), 1'b0, 11'(sh_len));
            send_ctl(MODE_START);
            need_start = 1'b0;
        end
    endtask

    // Stop, leave a packet part sent, reconfigure, then run random rounds
    task automatic run_phase(input logic [1:0] sz, input logic pat, input logic dep,
                             input logic cont, input int profile);
        int first;
        send_ctl(MODE_STOP);
        repeat ($urandom_range(sh_len, 1)) send_ctl(MODE_PULL);
        wait_quiet();
        load_config(sz, pat, dep, cont);
        case (profile)
            1:       begin send_idle_pct = 59; out_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  out_stall_pct = 59; end
            3:       begin send_idle_pct = 27; out_stall_pct = 27; end
            default: begin send_idle_pct = 0;  out_stall_pct = 0;  end
        endcase
        // queued packets are pulled under the new size
        repeat (3) send_ctl(MODE_PULL);
        need_start = 1'b1;
        first = words_applied;
        while (words_applied - first < PHASE_WORDS)
            play_round();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 27;
        out_stall_pct = 27;
        load_config(SIZE_32, PAT_DOWN, TWO_PACKETS, STOP_ON_ERR);
        wait_quiet();

        // Directed: empty pull, echo while idle, restart, zero length, full queue
        send_ctl(MODE_PULL);
        send_word(MODE_RX, 8'h05, 1'b0, 11'd3);
        send_word(MODE_RX, 8'hFF, 1'b1, 11'd1024);
        send_ctl(MODE_START);
        send_ctl(MODE_PULL);
        send_ctl(MODE_PULL);
        send_ctl(MODE_START);
        send_ctl(MODE_PULL);
        send_word(MODE_RX, 8'hFF, 1'b0, 11'd0);
        send_word(MODE_RX, 8'hAA, 1'b1, 11'd0);
        repeat (5) send_word(MODE_RX, 8'h00, 1'b1, 11'd1);
        // longest echo length, then a mismatch stops the test mid-echo
        send_word(MODE_RX, 8'hFF, 1'b0, 11'd1024);
        send_word(MODE_RX, 8'h00, 1'b0, 11'd1024);
        send_word(MODE_RX, 8'h55, 1'b1, 11'd1024);
        send_ctl(MODE_START);
        // a write while running must be dropped
        wait_quiet();
        write_reg(CFG_SIZE_SELECT, SIZE_250);
        cfg_write <= 1'b0;
        // stop inside an echo, then a pull still at the old size
        send_word(MODE_RX, 8'h01, 1'b0, 11'd2);
        send_ctl(MODE_STOP);
        send_word(MODE_RX, 8'h00, 1'b1, 11'd2);
        send_ctl(MODE_PULL);
        wait_quiet();

        // Random phases over settings and idle profiles
        run_phase(SIZE_32,     PAT_UP,   ONE_PACKET,  STOP_ON_ERR, 0);
        run_phase(SIZE_32_ALT, PAT_DOWN, TWO_PACKETS, KEEP_GOING,  1);
        run_phase(SIZE_128,    PAT_UP,   TWO_PACKETS, STOP_ON_ERR, 2);
        run_phase(SIZE_32,     PAT_DOWN, ONE_PACKET,  KEEP_GOING,  3);
        run_phase(SIZE_250,    PAT_DOWN, ONE_PACKET,  KEEP_GOING,  0);
        run_phase(SIZE_32_ALT, PAT_UP,   TWO_PACKETS, KEEP_GOING,  1);
        run_phase(SIZE_32,     PAT_DOWN, TWO_PACKETS, STOP_ON_ERR, 2);
        run_phase(SIZE_128,    PAT_DOWN, ONE_PACKET,  STOP_ON_ERR, 3);
        wait_quiet();

        $display("summary: %0d words over 9 register settings, %0d results checked",
                 words_applied, results_checked);
        $display("summary: %0d echo bytes flagged, %0d generated packets ended",
                 flagged_bytes, packets_closed);
        if (fail_count == 0 && results_waiting == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
